/* src/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg: shared constants and types for the throttle ramp
// Widths, codes and the request/response records between the sequencer and
// the serial duty unit.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

	// PWM compare resolution (valid range 8 to 16)
	localparam int DUTY_BITS = 16;

	// Throttle in Q8 percent, full scale is 100 percent
	localparam int              THR_W   = 15;
	localparam logic [THR_W-1:0] FULL_Q8 = 15'd25600;
	localparam logic [6:0]      TARGET_MAX = 7'd100;

	// Duty datapath widths
	localparam int NUM_W = 32;                       // pulse * 25600
	localparam int DEN_W = 31;                       // period * 25600
	localparam int QUO_W = 17;                       // 16 result bits plus overflow bit
	localparam int REM_W = (NUM_W + DUTY_BITS > DEN_W + QUO_W - 1) ?
		(NUM_W + DUTY_BITS) : (DEN_W + QUO_W - 1);
	localparam int MUL_STEPS = THR_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Duty after reset: minimum pulse of 1000 us in a 20000 us period
	localparam logic [15:0] DUTY_RST = 16'((1000 * ((1 << DUTY_BITS) - 1)) / 20000);

	// Item kinds
	localparam logic [1:0] FN_TICK = 2'd0;
	localparam logic [1:0] FN_SET  = 2'd1;
	localparam logic [1:0] FN_STOP = 2'd2;
	localparam logic [1:0] FN_NOP  = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_PULSE_MIN = 3'd0;
	localparam logic [2:0] REG_PULSE_MAX = 3'd1;
	localparam logic [2:0] REG_PERIOD    = 3'd2;
	localparam logic [2:0] REG_RAMP_STEP = 3'd3;
	localparam logic [2:0] REG_ARM_MS    = 3'd4;

	typedef struct packed {
		logic             start;
		logic [THR_W-1:0] throttle;
	} duty_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] duty;
	} duty_rsp_t;

endpackage

`default_nettype wire

/* src/esc_throttle_ramp_with_arming.sv */
// ----------------------------------------------------------------------------
// esc_throttle_ramp_with_arming: throttle slew limiter with arming delay
// Ramps a motor controller throttle toward its target and derives the PWM
// compare value whenever the throttle moves.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream (tuser holds the kind: tick, set target,
//   stop), one result per item leaves on the m_ stream. Registers are written
//   through cfg_we/cfg_addr/cfg_wdata; the user must do so only while no item
//   is in flight, as the block itself does not enforce it. One item at a time
//   is worked on. Set target, unused kinds, zero ticks and ticks that leave
//   the throttle where it is go from the control step to the final step. A
//   tick that moves the throttle, and a stop, run the serial duty unit: one
//   shift-and-add step per throttle bit, a scaling step and one divide step
//   per quotient bit; the result is offered once the duty unit is done, and
//   the next item is taken once the result is in the output register.
//   A finished result waits in the output register; the input side takes the
//   next item meanwhile, and that item holds in its last step until the
//   output register is free, so a stalled receiver stalls at most one item.
//   Reset (arst_n low) restores the register defaults, clears throttle,
//   target and arming count, and loads the zero-throttle duty.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_throttle_ramp_with_arming import esc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [7:0] elapsed_ms, [15:8] target_percent
	input  wire logic [1:0]  s_tuser,   // [1:0] func
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] duty, [16] duty_written,
	                                    // [23:17] current_percent, [30:24] target_now,
	                                    // [31] armed
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_WAITD = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       st_q;
	logic [1:0]       op_q;
	logic [7:0]       tp_q;
	logic [22:0]      step_q;
	logic [6:0]       target_q;
	logic [THR_W-1:0] thr_q;
	logic [15:0]      arm_q;
	logic [15:0]      duty_q;
	logic             written_q;
	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;

	logic [15:0]      pulse_min_q;
	logic [15:0]      pulse_max_q;
	logic [15:0]      period_q;
	logic [14:0]      ramp_step_q;
	logic [15:0]      arm_ms_q;

	logic             accept;
	logic             armed;
	logic [THR_W-1:0] goal;
	logic [THR_W-1:0] gap;
	logic [THR_W-1:0] thr_n;
	logic             moved;
	logic [16:0]      arm_sum;
	logic [15:0]      cur_q8r;
	logic             res_load;
	duty_req_t        dreq;
	duty_rsp_t        drsp;

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign armed    = (arm_q >= arm_ms_q);
	assign arm_sum  = {1'b0, arm_q} + 17'(s_tdata[7:0]);
	assign cur_q8r  = 16'(thr_q) + 16'd128;
	assign res_load = (st_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Ramp toward the effective target, stop at it
	always_comb begin
		goal  = armed ? {target_q, 8'b0} : '0;
		gap   = '0;
		thr_n = thr_q;
		moved = 1'b0;
		if (thr_q < goal) begin
			gap   = goal - thr_q;
			thr_n = (23'(gap) <= step_q) ? goal : (thr_q + step_q[THR_W-1:0]);
			moved = 1'b1;
		end else if (thr_q > goal) begin
			gap   = thr_q - goal;
			thr_n = (23'(gap) <= step_q) ? goal : (thr_q - step_q[THR_W-1:0]);
			moved = 1'b1;
		end
	end

	// Start the duty unit on a throttle change or a stop
	always_comb begin
		dreq.start    = (st_q == ST_EXEC) &&
			((op_q == FN_STOP) || ((op_q == FN_TICK) && moved));
		dreq.throttle = (op_q == FN_STOP) ? '0 : thr_n;
	end

	esc_duty_calc u_duty (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (dreq),
		.pulse_min_us (pulse_min_q),
		.pulse_max_us (pulse_max_q),
		.pwm_period   (period_q),
		.rsp          (drsp)
	);

	// Control, state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			op_q        <= FN_NOP;
			target_q    <= '0;
			thr_q       <= '0;
			arm_q       <= '0;
			duty_q      <= DUTY_RST;
			written_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			pulse_min_q <= 16'd1000;
			pulse_max_q <= 16'd2000;
			period_q    <= 16'd20000;
			ramp_step_q <= 15'd13;
			arm_ms_q    <= 16'd3000;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_PULSE_MIN: pulse_min_q <= cfg_wdata;
					REG_PULSE_MAX: pulse_max_q <= cfg_wdata;
					REG_PERIOD:    period_q    <= cfg_wdata;
					REG_RAMP_STEP: ramp_step_q <= cfg_wdata[14:0];
					REG_ARM_MS:    arm_ms_q    <= cfg_wdata;
					default: ;
				endcase
			end

			// raise a new result, drop one once transferred
			m_tvalid_q <= res_load || (m_tvalid_q && !m_tready);

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if ((s_tuser == FN_TICK) && (s_tdata[7:0] == 8'd0)) begin
							op_q <= FN_NOP;
						end else begin
							op_q <= s_tuser;
						end
						// advance the arming count, saturating
						if ((s_tuser == FN_TICK) && (s_tdata[7:0] != 8'd0))
							arm_q <= arm_sum[16] ? 16'hFFFF : arm_sum[15:0];
						st_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// a throttle change or a stop waits for the duty unit
					written_q <= dreq.start;
					st_q      <= dreq.start ? ST_WAITD : ST_FIN;
					unique case (op_q)
						FN_TICK: begin
							if (moved) thr_q <= thr_n;
						end
						FN_SET: begin
							target_q <= (tp_q > 8'(TARGET_MAX)) ? TARGET_MAX : tp_q[6:0];
						end
						FN_STOP: begin
							target_q  <= '0;
							thr_q     <= '0;
						end
						default: ;
					endcase
				end
				ST_WAITD: begin
					if (drsp.done) begin
						duty_q <= drsp.duty;
						st_q   <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (res_load) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tp_q   <= s_tdata[15:8];
			step_q <= 23'(ramp_step_q) * 23'(s_tdata[7:0]);
		end
		if (res_load)
			m_tdata_q <= {armed, target_q, cur_q8r[14:8], written_q, duty_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// One item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("item taken while another is in progress");

	// Duty unit answers only while waited on
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (st_q == ST_WAITD))
		else $error("duty unit finished outside its wait");

	// Throttle never passes full scale
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(thr_q <= FULL_Q8) && (target_q <= TARGET_MAX))
		else $error("throttle or target beyond full scale");

	// A result is raised only on leaving the final step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(st_q) == ST_FIN))
		else $error("result raised outside the final step");

endmodule

`default_nettype wire

/* src/esc_duty_calc.sv */
// ----------------------------------------------------------------------------
// esc_duty_calc: serial PWM duty unit
// Forms the pulse width times 25600 by shift-and-add over the throttle bits,
// scales by 2^DUTY_BITS-1 and divides by period times 25600 one quotient bit
// per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_duty_calc import esc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire duty_req_t req,
	input  wire logic [15:0] pulse_min_us,
	input  wire logic [15:0] pulse_max_us,
	input  wire logic [15:0] pwm_period,
	output duty_rsp_t      rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SCL  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]       st_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [15:0]      duty_q;

	logic [NUM_W-1:0] acc_q;
	logic [NUM_W-1:0] mcand_q;
	logic [THR_W-1:0] mplier_q;
	logic             neg_q;
	logic [DEN_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quo_q;

	logic [15:0]      per0;
	logic [22:0]      pmin100;
	logic [22:0]      per100;
	logic             ge;
	logic [QUO_W-1:0] quo_n;

	// Constant scaling by 100 as shifts and adds
	always_comb begin
		per0    = (pwm_period == 16'd0) ? 16'd1 : pwm_period;
		pmin100 = 23'({pulse_min_us, 6'b0}) + 23'({pulse_min_us, 5'b0})
			+ 23'({pulse_min_us, 2'b0});
		per100  = 23'({per0, 6'b0}) + 23'({per0, 5'b0}) + 23'({per0, 2'b0});
		ge      = (rem_q >= dsh_q);
		quo_n   = {quo_q[QUO_W-2:0], ge};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// flag the last divide step
			done_q <= (st_q == ST_DIV) && (cnt_q == CNT_W'(DIV_STEPS - 1));
			unique case (st_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (req.start) st_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						cnt_q <= '0;
						st_q  <= ST_SCL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCL: begin
					cnt_q <= '0;
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						st_q   <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: multiply, scale, divide
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (req.start) begin
					acc_q    <= NUM_W'({pmin100, 8'b0});
					neg_q    <= (pulse_max_us < pulse_min_us);
					mcand_q  <= (pulse_max_us < pulse_min_us) ?
						NUM_W'(pulse_min_us - pulse_max_us) :
						NUM_W'(pulse_max_us - pulse_min_us);
					mplier_q <= req.throttle;
					den_q    <= DEN_W'({per100, 8'b0});
				end
			end
			ST_MUL: begin
				// add or take off the shifted span for each set throttle bit
				if (mplier_q[0]) acc_q <= neg_q ? (acc_q - mcand_q) : (acc_q + mcand_q);
				mcand_q  <= {mcand_q[NUM_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[THR_W-1:1]};
			end
			ST_SCL: begin
				// times (2^DUTY_BITS - 1)
				rem_q <= REM_W'({acc_q, {DUTY_BITS{1'b0}}}) - REM_W'(acc_q);
				dsh_q <= REM_W'({den_q, {(QUO_W-1){1'b0}}});
			end
			ST_DIV: begin
				// one restoring step per cycle, top quotient bit flags overflow
				if (ge) rem_q <= rem_q - dsh_q;
				dsh_q <= {1'b0, dsh_q[REM_W-1:1]};
				quo_q <= quo_n;
				if (cnt_q == CNT_W'(DIV_STEPS - 1))
					duty_q <= quo_n[QUO_W-1] ? 16'hFFFF : quo_n[15:0];
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.duty = duty_q;

endmodule

`default_nettype wire

/* tb/sv/esc_throttle_ramp_with_arming_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esc_throttle_ramp_with_arming_test: self-checking bench for the throttle ramp
// Drives tick, set-target, stop and unused items into the input stream and
// checks every status word on the result stream. The expected words come from
// a cycle-free model of the ramp, the arming counter and the duty divide. The
// run covers directed corners, a long output stall, arming saturation and
// random traffic under changing idle patterns and register settings.
// ----------------------------------------------------------------------------

module esc_throttle_ramp_with_arming_test;

	import esc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;
	localparam int SETTLE_CYCLES = 48;

	// Status word as it leaves on m_tdata, top bit first
	typedef struct packed {
		logic        armed;
		logic [6:0]  target;
		logic [6:0]  pct;
		logic        written;
		logic [15:0] duty;
	} esc_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] elapsed_ms, [15:8] target_percent
	logic [1:0]  s_tuser = FN_NOP;   // [1:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // [15:0] duty, [16] duty_written, [23:17] current_percent,
	                        // [30:24] target_now, [31] armed
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = REG_PULSE_MIN;
	logic [15:0] cfg_wdata = '0;

	// Register copies, as after reset
	int unsigned cfg_pulse_min = 1000;
	int unsigned cfg_pulse_max = 2000;
	int unsigned cfg_period = 20000;
	int unsigned cfg_ramp = 13;
	int unsigned cfg_arm_ms = 3000;

	// Ramp state copies
	int unsigned tgt_level = 0;
	int unsigned thr_q8 = 0;
	int unsigned arm_cnt = 0;
	logic [15:0] duty_now;

	esc_status_t due_status[$];
	int mismatches = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	esc_throttle_ramp_with_arming DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Exact duty for a throttle level: pulse scaled to the full compare range
	function automatic logic [15:0] duty_of(input int unsigned thr);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		logic [63:0] lvl;
		int unsigned per;
		per = (cfg_period == 0) ? 1 : cfg_period;
		lvl = (thr > FULL_Q8) ? 64'(FULL_Q8) : 64'(thr);
		if (cfg_pulse_max >= cfg_pulse_min) begin
			num = 64'(cfg_pulse_min) * FULL_Q8 + 64'(cfg_pulse_max - cfg_pulse_min) * lvl;
		end else begin
			num = 64'(cfg_pulse_min) * FULL_Q8 - 64'(cfg_pulse_min - cfg_pulse_max) * lvl;
		end
		den = 64'(FULL_Q8) * per;
		quo = (num * ((64'd1 << DUTY_BITS) - 1)) / den;
		return (quo > 65535) ? 16'hFFFF : quo[15:0];
	endfunction

	// Apply one item to the ramp state and return the status it leaves
	function automatic esc_status_t advance_throttle(input logic [1:0] fn,
			input logic [7:0] el, input logic [7:0] tp);
		esc_status_t st;
		int unsigned goal;
		int unsigned stride;
		logic moved;
		moved = 1'b0;
		case (fn)
			FN_TICK: if (el != 0) begin
				arm_cnt = (arm_cnt + el > 65535) ? 65535 : arm_cnt + el;
				goal = (arm_cnt >= cfg_arm_ms) ? tgt_level * 256 : 0;
				stride = cfg_ramp * el;
				if (thr_q8 < goal) begin
					thr_q8 = (goal - thr_q8 <= stride) ? goal : thr_q8 + stride;
					moved = 1'b1;
				end else if (thr_q8 > goal) begin
					thr_q8 = (thr_q8 - goal <= stride) ? goal : thr_q8 - stride;
					moved = 1'b1;
				end
				if (moved)
					duty_now = duty_of(thr_q8);
			end
			FN_SET: tgt_level = (tp > TARGET_MAX) ? TARGET_MAX : tp;
			FN_STOP: begin
				tgt_level = 0;
				thr_q8 = 0;
				duty_now = duty_of(0);
				moved = 1'b1;
			end
			default: ;
		endcase
		st.duty = duty_now;
		st.written = moved;
		st.pct = 7'((thr_q8 + 128) >> 8);
		st.target = 7'(tgt_level);
		st.armed = (arm_cnt >= cfg_arm_ms);
		return st;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
	endtask

	// Compare one status word with the oldest expectation
	task automatic check_status(input esc_status_t got);
		esc_status_t want;
		if (due_status.size() == 0) begin
			report_mismatch("status with none pending", got, '0);
			return;
		end
		want = due_status.pop_front();
		if (got.duty !== want.duty)
			report_mismatch("duty", got.duty, want.duty);
		if (got.written !== want.written)
			report_mismatch("duty_written", got.written, want.written);
		if (got.pct !== want.pct)
			report_mismatch("current_percent", got.pct, want.pct);
		if (got.target !== want.target)
			report_mismatch("target_now", got.target, want.target);
		if (got.armed !== want.armed)
			report_mismatch("armed", got.armed, want.armed);
	endtask

	// Result side: check each transfer, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_status(m_tdata);
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Abort a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offer one item until it is taken, then predict its status
	task automatic send_item(input logic [1:0] fn, input logic [7:0] el, input logic [7:0] tp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {tp, el};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		due_status.push_back(advance_throttle(fn, el, tp));
	endtask

	// Hold the input side until every status has come back and the block is quiet
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_PULSE_MIN: cfg_pulse_min = val;
			REG_PULSE_MAX: cfg_pulse_max = val;
			REG_PERIOD:    cfg_period = val;
			REG_RAMP_STEP: cfg_ramp = val[14:0];
			REG_ARM_MS:    cfg_arm_ms = val;
			default: ;
		endcase
	endtask

	// Rewrite every register once the block is idle
	task automatic load_settings(input int unsigned pmin, input int unsigned pmax,
			input int unsigned per, input int unsigned ramp, input int unsigned arm);
		drain_results();
		write_reg(REG_PULSE_MIN, 16'(pmin));
		write_reg(REG_PULSE_MAX, 16'(pmax));
		write_reg(REG_PERIOD, 16'(per));
		write_reg(REG_RAMP_STEP, 16'(ramp));
		write_reg(REG_ARM_MS, 16'(arm));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly ticks with short elapsed times so the ramp spends time between levels
	task automatic send_random_items(input int count);
		int pick;
		logic [1:0] fn;
		logic [7:0] el;
		logic [7:0] tp;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 4)
				fn = FN_STOP;
			else if (pick < 8)
				fn = FN_NOP;
			else if (pick < 33)
				fn = FN_SET;
			else
				fn = FN_TICK;
			pick = $urandom_range(99);
			if (pick < 8)
				el = 8'd0;
			else if (pick < 65)
				el = 8'($urandom_range(1, 12));
			else
				el = 8'($urandom_range(0, 255));
			pick = $urandom_range(99);
			if (pick < 60)
				tp = 8'($urandom_range(0, 100));
			else if (pick < 75)
				tp = TARGET_MAX;
			else
				tp = 8'($urandom_range(0, 255));
			send_item(fn, el, tp);
		end
	endtask

	// Unarmed after reset: target saturates, throttle stays at zero
	task automatic test_power_up_defaults();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		send_item(FN_NOP, 8'hFF, 8'hFF);
		send_item(FN_TICK, 8'd0, 8'hFF);
		send_item(FN_SET, 8'hFF, 8'hFF);
		send_item(FN_TICK, 8'hFF, 8'h00);
		send_item(FN_SET, 8'h00, 8'd100);
		send_item(FN_TICK, 8'd1, 8'h00);
		send_item(FN_STOP, 8'hFF, 8'hFF);
		send_item(FN_SET, 8'h00, 8'h00);
	endtask

	// Armed from the start with a full-scale step: jump to target and back
	task automatic test_full_ramp();
		load_settings(1000, 2000, 20000, FULL_Q8, 0);
		send_item(FN_SET, 8'h00, 8'd100);
		send_item(FN_TICK, 8'd1, 8'h00);
		send_item(FN_TICK, 8'd255, 8'h00);
		send_item(FN_SET, 8'h00, 8'd0);
		send_item(FN_TICK, 8'd1, 8'h00);
		send_item(FN_SET, 8'h00, 8'd37);
		send_item(FN_TICK, 8'd3, 8'h00);
		send_item(FN_STOP, 8'h00, 8'h00);
	endtask

	// Falling pulse, zero period, saturated duty, then a zero ramp step
	task automatic test_pulse_corners();
		load_settings(65535, 0, 0, 256, 0);
		send_item(FN_SET, 8'h00, 8'd100);
		send_item(FN_TICK, 8'd2, 8'h00);
		send_item(FN_TICK, 8'd255, 8'h00);
		send_item(FN_STOP, 8'h00, 8'h00);
		load_settings(0, 65535, 65535, 0, 0);
		send_item(FN_SET, 8'h00, 8'd50);
		send_item(FN_TICK, 8'd1, 8'h00);
	endtask

	// Arming ends part way through a run of ticks
	task automatic test_arming_delay();
		load_settings(1000, 2000, 20000, 1000, (arm_cnt + 300 > 65535) ? 65535 : arm_cnt + 300);
		send_item(FN_SET, 8'h00, 8'd60);
		send_item(FN_TICK, 8'd200, 8'h00);
		send_item(FN_TICK, 8'd200, 8'h00);
		send_item(FN_TICK, 8'd255, 8'h00);
	endtask

	// Long output stall while items keep coming: the input side must back up
	task automatic test_output_backpressure();
		load_settings(1000, 2000, 20000, 40, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 300;
		send_random_items(16);
		drain_results();
	endtask

	// Drive the arming counter into saturation with the longest arming time
	task automatic test_arm_saturation();
		load_settings(1500, 1000, 5000, 200, 65535);
		send_idle_pct = 5;
		recv_idle_pct = 5;
		send_item(FN_SET, 8'h00, 8'd90);
		while (arm_cnt < 65535)
			send_item(FN_TICK, 8'd255, 8'h00);
		send_item(FN_TICK, 8'd4, 8'h00);
	endtask

	task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int count);
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		send_random_items(count);
	endtask

	initial begin
		duty_now = duty_of(0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_defaults();
		test_full_ramp();
		test_pulse_corners();
		test_arming_delay();
		test_output_backpressure();

		// Sender mostly busy, receiver mostly stalled; arming ends mid-phase
		load_settings(1000, 2000, 20000, $urandom_range(1, 200),
			(arm_cnt + 2500 > 65535) ? 65535 : arm_cnt + 2500);
		test_random_traffic(24, 81, 330);

		// Full pulse span over the longest period, roles swapped
		load_settings(0, 65535, 65535, $urandom_range(1, 60), 0);
		test_random_traffic(81, 24, 330);

		test_arm_saturation();

		// Random pulse limits, often falling, with no idling at all
		load_settings($urandom_range(0, 3000), $urandom_range(0, 3000),
			$urandom_range(2000, 65535), $urandom_range(1, 2000), 65535);
		test_random_traffic(0, 0, 330);

		drain_results();
		if (mismatches == 0 && due_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
